/* rtl/lid_pkg.sv */
// Shared types and constants for the two-line intersection pipeline.
// No dependencies; the top level takes everything by scoped name.
package lid_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DW            = 32;  // coordinate width
  localparam int unsigned QW            = 32;  // quotient bits produced
  localparam int unsigned DMW           = 64;  // denominator magnitude width
  localparam int unsigned NMW           = 65;  // numerator magnitude width
  localparam int unsigned CFG_IDX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_THRESH = 8'd1;
  localparam logic [DW-1:0]        PAR_THRESH_RST = 32'd4295;

  localparam logic signed [DW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] SAT_MIN = 32'sh8000_0000;

  // data that rides alongside the arithmetic
  typedef struct packed {
    logic [2:0][DW-1:0] p1;
    logic [2:0][DW-1:0] v1;
    logic [2:0][DW-1:0] mid;
    logic               par;
    logic               tneg;
  } side_t;

  // one divider stage
  typedef struct packed {
    logic [DMW-1:0] rem;
    logic [QW-1:0]  q;
    logic [QW-1:0]  lo;
    logic [DMW-1:0] d;
    logic           ovf;
    side_t          side;
  } div_t;

endpackage

/* rtl/line_intersect_2d_unit.sv */
// Two-line intersection pipeline, top level.
// Depends on lid_pkg (types, constants).
//
// Each input transaction carries two lines (point + direction, Q16.16 by
// default) and produces exactly one result transaction at the end of the
// pipeline: 4 front stages, QW (32) restoring-division stages, one multiply
// stage and the output register. A new transaction is taken every cycle,
// one per clock, limited only by the output side: while the output register
// holds an untaken result the whole pipeline holds, otherwise it advances.
// plane_mode selects XY (0) or XZ (1); if the denominator magnitude is zero
// or below parallel_threshold, the floor midpoint of the two points is
// returned and lines_parallel is set. The user must write configuration
// via the cfg channel (always ready) only while idle; this is not enforced.
module line_intersect_2d_unit #(
  parameter int unsigned FRAC_BITS = lid_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  // input transactions
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_first_x,
  input  logic signed [31:0]              in_first_y,
  input  logic signed [31:0]              in_first_z,
  input  logic signed [31:0]              in_first_dir_x,
  input  logic signed [31:0]              in_first_dir_y,
  input  logic signed [31:0]              in_first_dir_z,
  input  logic signed [31:0]              in_second_x,
  input  logic signed [31:0]              in_second_y,
  input  logic signed [31:0]              in_second_z,
  input  logic signed [31:0]              in_second_dir_x,
  input  logic signed [31:0]              in_second_dir_y,
  input  logic signed [31:0]              in_second_dir_z,
  // result transactions
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              out_cross_x,
  output logic signed [31:0]              out_cross_y,
  output logic signed [31:0]              out_cross_z,
  output logic                            out_lines_parallel
);

  localparam int unsigned DW  = lid_pkg::DW;
  localparam int unsigned QW  = lid_pkg::QW;
  localparam int unsigned DMW = lid_pkg::DMW;
  localparam int unsigned NMW = lid_pkg::NMW;
  localparam int unsigned XW  = NMW + FRAC_BITS;  // scaled numerator width
  localparam int unsigned HW  = XW - QW;          // part above the quotient bits

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic          plane_mode_r;
  logic [31:0]   par_thresh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_mode_r <= 1'b0;
      par_thresh_r <= lid_pkg::PAR_THRESH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lid_pkg::REG_PLANE_MODE: plane_mode_r <= cfg_data[0];
        lid_pkg::REG_PAR_THRESH: par_thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: the pipeline moves whenever the output register is
  // empty or being drained this cycle.
  // ---------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------------
  // Stage 1: axis select, point differences, the four cross-product terms
  // and the midpoint.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0]   v1b, v2b, p1b, p2b;
  logic signed [DW:0]     da, db;
  logic signed [2*DW-1:0] m0_nxt, m1_nxt;
  logic signed [2*DW:0]   m2_nxt, m3_nxt;
  lid_pkg::side_t         side1_nxt;
  logic signed [DW:0]     psum [3];

  always_comb begin
    v1b = plane_mode_r ? in_first_dir_z  : in_first_dir_y;
    v2b = plane_mode_r ? in_second_dir_z : in_second_dir_y;
    p1b = plane_mode_r ? in_first_z      : in_first_y;
    p2b = plane_mode_r ? in_second_z     : in_second_y;
    da  = (DW+1)'(in_second_x) - (DW+1)'(in_first_x);
    db  = (DW+1)'(p2b) - (DW+1)'(p1b);
    m0_nxt = in_first_dir_x * v2b;
    m1_nxt = v1b * in_second_dir_x;
    m2_nxt = da * v2b;
    m3_nxt = db * in_second_dir_x;
    psum[0] = (DW+1)'(in_first_x) + (DW+1)'(in_second_x);
    psum[1] = (DW+1)'(in_first_y) + (DW+1)'(in_second_y);
    psum[2] = (DW+1)'(in_first_z) + (DW+1)'(in_second_z);
    side1_nxt.p1   = {in_first_z, in_first_y, in_first_x};
    side1_nxt.v1   = {in_first_dir_z, in_first_dir_y, in_first_dir_x};
    side1_nxt.mid  = {psum[2][DW:1], psum[1][DW:1], psum[0][DW:1]};
    side1_nxt.par  = 1'b0;
    side1_nxt.tneg = 1'b0;
  end

  logic                   s1_v_r;
  logic signed [2*DW-1:0] m0_r, m1_r;
  logic signed [2*DW:0]   m2_r, m3_r;
  lid_pkg::side_t         side1_r;

  // ---------------------------------------------------------------------
  // Stage 2: exact denominator and numerator.
  // ---------------------------------------------------------------------
  logic                   s2_v_r;
  logic signed [2*DW:0]   den_r;
  logic signed [2*DW+1:0] num_r;
  lid_pkg::side_t         side2_r;

  // ---------------------------------------------------------------------
  // Stage 3: magnitudes, signs, parallel decision.
  // ---------------------------------------------------------------------
  logic [2*DW:0]          den_abs;
  logic [2*DW+1:0]        num_abs;
  logic [DMW-1:0]         dmag_nxt;
  logic                   par_nxt;
  lid_pkg::side_t         side3_nxt;

  always_comb begin
    den_abs   = den_r[2*DW] ? (2*DW+1)'(-den_r) : den_r;
    num_abs   = num_r[2*DW+1] ? (2*DW+2)'(-num_r) : num_r;
    dmag_nxt  = den_abs[DMW-1:0];
    par_nxt   = (dmag_nxt == '0) || (dmag_nxt < DMW'(par_thresh_r));
    side3_nxt = side2_r;
    side3_nxt.par  = par_nxt;
    side3_nxt.tneg = num_r[2*DW+1] ^ den_r[2*DW];
  end

  logic                   s3_v_r;
  logic [DMW-1:0]         dmag_r;
  logic [NMW-1:0]         nmag_r;
  lid_pkg::side_t         side3_r;

  // ---------------------------------------------------------------------
  // Stage 4: scale the numerator, flag quotient overflow (q >= 2^QW) and
  // seed the divider with the part above the quotient bits.
  // ---------------------------------------------------------------------
  logic [XW-1:0] xnum;
  logic [HW-1:0] xhi;
  lid_pkg::div_t div0_nxt;

  always_comb begin
    xnum          = {nmag_r, {FRAC_BITS{1'b0}}};
    xhi           = xnum[XW-1:QW];
    div0_nxt.rem  = DMW'(xhi);
    div0_nxt.q    = '0;
    div0_nxt.lo   = xnum[QW-1:0];
    div0_nxt.d    = dmag_r;
    div0_nxt.ovf  = (DMW'(xhi) >= dmag_r);
    div0_nxt.side = side3_r;
  end

  logic          s4_v_r;
  lid_pkg::div_t div0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r    <= m0_nxt;
      m1_r    <= m1_nxt;
      m2_r    <= m2_nxt;
      m3_r    <= m3_nxt;
      side1_r <= side1_nxt;
      den_r   <= (2*DW+1)'(m0_r) - (2*DW+1)'(m1_r);
      num_r   <= (2*DW+2)'(m2_r) - (2*DW+2)'(m3_r);
      side2_r <= side1_r;
      dmag_r  <= dmag_nxt;
      nmag_r  <= num_abs[NMW-1:0];
      side3_r <= side3_nxt;
      div0_r  <= div0_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage.
  // ---------------------------------------------------------------------
  lid_pkg::div_t dstg_r [1:QW];
  logic [QW:1]   dv_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    lid_pkg::div_t cur;
    logic [DMW:0]  r2;
    logic          ge;
    logic [DMW:0]  rdiff;
    lid_pkg::div_t step_nxt;

    if (k == 0) begin : g_first
      assign cur = div0_r;
    end else begin : g_next
      assign cur = dstg_r[k];
    end

    always_comb begin
      r2       = {cur.rem, cur.lo[QW-1]};
      rdiff    = r2 - {1'b0, cur.d};
      ge       = (r2 >= {1'b0, cur.d});
      step_nxt = cur;
      step_nxt.rem = ge ? rdiff[DMW-1:0] : r2[DMW-1:0];
      step_nxt.q   = {cur.q[QW-2:0], ge};
      step_nxt.lo  = {cur.lo[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dstg_r[k+1] <= step_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Multiply stage: saturate t and form t * v1 for all three lanes.
  // ---------------------------------------------------------------------
  lid_pkg::div_t          dq;
  logic signed [DW-1:0]   t_val;
  logic                   qtop;

  always_comb begin
    dq   = dstg_r[QW];
    qtop = dq.q[QW-1];
    if (dq.side.tneg) begin
      t_val = (dq.ovf || qtop) ? lid_pkg::SAT_MIN : DW'(-$signed(dq.q));
    end else begin
      t_val = (dq.ovf || qtop) ? lid_pkg::SAT_MAX : $signed(dq.q);
    end
  end

  logic                   sm_v_r;
  logic signed [2*DW-1:0] prod_r [3];
  lid_pkg::side_t         sidem_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= t_val * $signed(dq.side.v1[i]);
      end
      sidem_r <= dq.side;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: p1 + floor(t*v1 / 2^F), saturated, or the midpoint; z is zero in XY mode.
  // ---------------------------------------------------------------------
  logic signed [2*DW-1:0] acc [3];
  logic signed [DW-1:0]   res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (2*DW)'($signed(sidem_r.p1[i])) + (prod_r[i] >>> FRAC_BITS);
      if (sidem_r.par) begin
        res[i] = $signed(sidem_r.mid[i]);
      end else if (acc[i] > (2*DW)'(lid_pkg::SAT_MAX)) begin
        res[i] = lid_pkg::SAT_MAX;
      end else if (acc[i] < (2*DW)'(lid_pkg::SAT_MIN)) begin
        res[i] = lid_pkg::SAT_MIN;
      end else begin
        res[i] = acc[i][DW-1:0];
      end
    end
  end

  logic signed [DW-1:0] cx_r, cy_r, cz_r;
  logic                 par_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r  <= res[0];
      cy_r  <= res[1];
      cz_r  <= plane_mode_r ? res[2] : '0;
      par_r <= sidem_r.par;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      dv_r        <= '0;
      sm_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      dv_r        <= {dv_r[QW-1:1], s4_v_r};
      sm_v_r      <= dv_r[QW];
      out_valid_r <= sm_v_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cross_x        = cx_r;
  assign out_cross_y        = cy_r;
  assign out_cross_z        = cz_r;
  assign out_lines_parallel = par_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s1_v_r, s2_v_r, s3_v_r, s4_v_r, dv_r[QW:1], sm_v_r}))
    else $error("pipeline valid bits moved during a stall");

  a_nonpar_den: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !div0_r.side.par |-> div0_r.d != '0)
    else $error("zero denominator reached the divider as non-parallel");

  a_xy_zero_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !plane_mode_r |-> out_cross_z == '0)
    else $error("z result non-zero in XY mode");

endmodule
